>>> sv/leb_pkg.sv
`default_nettype none

package leb_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned GroupW   = 7;
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned LenW     = 4;

  localparam logic [7:0] PayloadMask = 8'h7F;
  localparam logic [7:0] MoreBit     = 8'h80;
  localparam logic [7:0] SignBit     = 8'h40;

  localparam logic ModeUnsigned = 1'b0;
  localparam logic ModeSigned   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StSize,
    StEmit
  } leb_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input beat
    logic size;   // register encoded length
    logic shift;  // step to the next group
  } leb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // current byte is the final one
  } leb_stat_t;

endpackage

`default_nettype wire

>>> sv/leb128_encoder.sv
// LEB128 encoder.
// Input channel (in_valid_i / in_ready_o): one beat carries a 64-bit value_i
// and cmd_i (0 unsigned, 1 signed two's complement).
// Output channel (out_valid_o / out_ready_i): one beat per encoded byte, least
// significant group first; out_byte_o bit 7 marks a following byte, last_o
// flags the final byte and total_bytes_o (1 to 10) rides on every beat.
// Timing: after an input beat is taken, state StSize registers the encoded
// length, then bytes go out one per cycle while the receiver is ready.
// An item of N bytes passes through the sizing state and then N output
// beats, one per byte; the next input beat is taken once back in idle.
// One item is in flight at a time: in_ready_o is high only when idle.
// A stalled receiver simply holds the current byte and all state; nothing
// is dropped. Reset returns the controller to idle with no output pending.
`default_nettype none

module leb128_encoder
  import leb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         cmd_i,
  input  wire logic [63:0]  value_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o,
  output logic [3:0]        total_bytes_o
);

  leb_cmd_t  cmd;
  leb_stat_t stat;

  leb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  leb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_mode_i    (cmd_i),
    .value_i       (value_i),
    .stat_o        (stat),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .total_bytes_o (total_bytes_o)
  );

endmodule

`default_nettype wire

>>> sv/leb_ctrl.sv
`default_nettype none

module leb_ctrl
  import leb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire leb_stat_t stat_i,
  output leb_cmd_t       cmd_o
);

  leb_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StSize;
      end
      StSize: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i && stat_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StSize: begin
        cmd_o.size = 1'b1;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/leb_dpath.sv
`default_nettype none

module leb_dpath
  import leb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire leb_cmd_t          cmd_i,
  input  wire logic              cmd_mode_i,
  input  wire logic [ValueW-1:0] value_i,
  output leb_stat_t              stat_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_o,
  output logic [LenW-1:0]        total_bytes_o
);

  logic              mode_q;
  logic [ValueW-1:0] sh_q, sh_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   idx_q;
  logic              last;
  logic              fill;

  // encoded length: smallest byte count whose groups hold the whole value
  always_comb begin
    logic signed [ValueW-1:0] sv;
    logic        [ValueW-1:0] uv;
    sv    = $signed(sh_q);
    len_d = LenW'(MaxBytes);
    for (int n = MaxBytes - 1; n >= 1; n--) begin
      if (mode_q == ModeSigned) begin
        uv = ValueW'(sv >>> (GroupW * n - 1));
        if (uv == '0 || uv == '1) len_d = LenW'(n);
      end else begin
        uv = sh_q >> (GroupW * n);
        if (uv == '0) len_d = LenW'(n);
      end
    end
  end

  // group shifter, sign fill in signed mode
  assign fill = (mode_q == ModeSigned) & sh_q[ValueW-1];
  assign sh_d = {{GroupW{fill}}, sh_q[ValueW-1:GroupW]};

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= cmd_mode_i;
      sh_q   <= value_i;
    end else if (cmd_i.shift) begin
      sh_q   <= sh_d;
    end
    if (cmd_i.size) len_q <= len_d;
  end

  // byte index within the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.size) begin
      idx_q <= LenW'(1);
    end else if (cmd_i.shift) begin
      idx_q <= idx_q + LenW'(1);
    end
  end

  assign last        = (idx_q == len_q);
  assign stat_o.last = last;

  // result beat
  assign out_byte_o    = (sh_q[7:0] & PayloadMask) | (last ? 8'h00 : MoreBit);
  assign last_o        = last;
  assign total_bytes_o = len_q;

endmodule

`default_nettype wire
